// File: hdl/utf8d_pkg.sv
package utf8d_pkg;

	// automaton state codes: accept, reject, then pending states
	typedef logic [3:0] dfa_st_t;
	typedef logic [3:0] byte_cls_t;

	localparam dfa_st_t DFA_ACCEPT = 4'd0;
	localparam dfa_st_t DFA_REJECT = 4'd1;
	localparam int unsigned DFA_STATES = 9;
	localparam int unsigned CLS_COUNT = 12;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK        = 2'd0;
	localparam status_t STAT_MALFORMED = 2'd1;
	localparam status_t STAT_TRUNCATED = 2'd2;

	// line-ending style
	typedef logic [1:0] nl_style_t;
	localparam nl_style_t NL_NONE = 2'd0;
	localparam nl_style_t NL_LF   = 2'd1;
	localparam nl_style_t NL_CR   = 2'd2;

	localparam int unsigned CP_BITS = 21;
	typedef logic [CP_BITS-1:0] cp_t;

	localparam cp_t CP_LF  = 21'h00000A;
	localparam cp_t CP_CR  = 21'h00000D;
	localparam cp_t CP_BOM = 21'h00FEFF;
	localparam cp_t CP_MAX = 21'h10FFFF;

	// transition table, one row per state, one column per byte class
	localparam dfa_st_t NEXT_TBL [DFA_STATES][CLS_COUNT] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
		'{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
		'{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
		'{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
	};

	// map a raw byte to its class
	function automatic byte_cls_t byte_class(input logic [7:0] b);
		byte_cls_t c;
		case (b) inside
			[8'h00:8'h7F]: c = 4'd0;
			[8'h80:8'h8F]: c = 4'd1;
			[8'h90:8'h9F]: c = 4'd9;
			[8'hA0:8'hBF]: c = 4'd7;
			8'hC0, 8'hC1:  c = 4'd8;
			[8'hC2:8'hDF]: c = 4'd2;
			8'hE0:         c = 4'd10;
			8'hED:         c = 4'd4;
			[8'hE1:8'hEF]: c = 4'd3;
			8'hF0:         c = 4'd11;
			[8'hF1:8'hF3]: c = 4'd6;
			8'hF4:         c = 4'd5;
			default:       c = 4'd8;
		endcase
		return c;
	endfunction

	// one automaton step; unused state codes behave as reject
	function automatic dfa_st_t dfa_next(input dfa_st_t st, input byte_cls_t cls);
		dfa_st_t row;
		row = (st < 4'(DFA_STATES)) ? st : DFA_REJECT;
		return NEXT_TBL[row][cls];
	endfunction

endpackage

// File: hdl/utf8_byte_decoder.sv
// an accepted byte is held in the input stage, then registered into the result stage
// throughput: one byte item per cycle; a stall on the result side holds both stages
// the only loop is the registered state update from the automaton table and counters
// arst_n clears the pipeline, the string state (line and column at 1) and strip_bom
// string state also returns to its reset values after each byte marked tlast
module utf8_byte_decoder #(
	parameter int unsigned LINE_BITS = 32,
	parameter int unsigned COL_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,    // strip_bom
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // in_byte
	input  logic        s_tlast,      // string_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,      // codepoint, status, line_no, col_no, zero pad
	output logic        m_tuser,      // cp_valid
	output logic        m_tlast       // end_seen
);
	import utf8d_pkg::*;

	// pipeline registers
	logic            vld_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;
	logic            vld_s2;
	logic            cpv_s2;
	cp_t             cp_s2;
	status_t         stat_s2;
	logic [31:0]     line_s2;
	logic [31:0]     col_s2;
	logic            last_s2;

	// string state
	logic            bom_q;
	dfa_st_t         dfa_q;
	cp_t             part_q;
	logic [LINE_BITS-1:0] line_q;
	logic [COL_BITS-1:0]  col_q;
	nl_style_t       nl_q;
	logic            start_q;
	logic            err_q;

	// next values
	byte_cls_t       cls;
	dfa_st_t         dfa_d;
	cp_t             part_d;
	logic [LINE_BITS-1:0] line_d;
	logic [COL_BITS-1:0]  col_d;
	nl_style_t       nl_d;
	logic            start_d;
	logic            err_d;
	logic            cpv_d;
	cp_t             cp_d;
	status_t         stat_d;
	logic            is_lf;
	logic            is_cr;
	logic            advance;
	logic            fire;
	logic [63:0]     line_ext;
	logic [63:0]     col_ext;

	// handshake: both stages move together when the result slot is free
	assign advance  = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || advance;
	assign fire     = vld_s1 && advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bom_q <= 1'b0;
		end else if (cfg_we) begin
			bom_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// decode step for the byte in the input stage
	always_comb begin
		cls     = byte_class(byte_s1);
		dfa_d   = dfa_q;
		part_d  = part_q;
		line_d  = line_q;
		col_d   = col_q;
		nl_d    = nl_q;
		start_d = start_q;
		err_d   = err_q;
		cpv_d   = 1'b0;
		cp_d    = '0;
		stat_d  = STAT_OK;
		is_lf   = 1'b0;
		is_cr   = 1'b0;
		if (err_q) begin
			stat_d = STAT_MALFORMED;
		end else begin
			if (dfa_q != DFA_ACCEPT) begin
				part_d = {part_q[CP_BITS-7:0], byte_s1[5:0]};
			end else begin
				part_d = CP_BITS'((8'hFF >> cls) & byte_s1);
			end
			dfa_d = dfa_next(dfa_q, cls);
			is_lf = (part_d == CP_LF);
			is_cr = (part_d == CP_CR);
			if (dfa_d == DFA_REJECT) begin
				err_d   = 1'b1;
				start_d = 1'b0;
				stat_d  = STAT_MALFORMED;
			end else if (dfa_d == DFA_ACCEPT) begin
				start_d = 1'b0;
				if (!(start_q && bom_q && part_d == CP_BOM)) begin
					cpv_d = 1'b1;
					cp_d  = part_d;
					if ((nl_q == NL_NONE && (is_lf || is_cr)) ||
					    (nl_q == NL_LF && is_lf) || (nl_q == NL_CR && is_cr)) begin
						if (nl_q == NL_NONE) begin
							nl_d = is_lf ? NL_LF : NL_CR;
						end
						col_d  = COL_BITS'(1);
						line_d = (&line_q) ? line_q : line_q + LINE_BITS'(1);
					end else if (!(is_lf || is_cr)) begin
						col_d = (&col_q) ? col_q : col_q + COL_BITS'(1);
					end
				end
			end else if (last_s1) begin
				stat_d = STAT_TRUNCATED;
			end
		end
	end

	// string state update, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dfa_q   <= DFA_ACCEPT;
			part_q  <= '0;
			line_q  <= LINE_BITS'(1);
			col_q   <= COL_BITS'(1);
			nl_q    <= NL_NONE;
			start_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				dfa_q   <= DFA_ACCEPT;
				part_q  <= '0;
				line_q  <= LINE_BITS'(1);
				col_q   <= COL_BITS'(1);
				nl_q    <= NL_NONE;
				start_q <= 1'b1;
				err_q   <= 1'b0;
			end else begin
				dfa_q   <= dfa_d;
				part_q  <= part_d;
				line_q  <= line_d;
				col_q   <= col_d;
				nl_q    <= nl_d;
				start_q <= start_d;
				err_q   <= err_d;
			end
		end
	end

	// counters widened or cut to the 32-bit result fields
	assign line_ext = 64'(line_d);
	assign col_ext  = 64'(col_d);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			cpv_s2  <= cpv_d;
			cp_s2   <= cp_d;
			stat_s2 <= stat_d;
			line_s2 <= line_ext[31:0];
			col_s2  <= col_ext[31:0];
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = cpv_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {1'b0, col_s2, line_s2, stat_s2, cp_s2};

	// a delivered code point never carries an error status
	a_cp_ok : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[22:21] == STAT_OK))
		else $error("code point delivered with non-ok status");

	// the automaton never yields a value beyond the unicode range
	a_cp_range : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[20:0] <= CP_MAX))
		else $error("code point out of range");

	// a malformed byte inside a string latches the error
	a_err_latch : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !last_s1 && stat_d == STAT_MALFORMED) |=> err_q)
		else $error("error not latched");

	// the final byte of a string restores the start-of-string state
	a_end_clear : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (dfa_q == DFA_ACCEPT && start_q && !err_q &&
		line_q == LINE_BITS'(1) && col_q == COL_BITS'(1)))
		else $error("string state not cleared at string end");

	// counters never wrap to zero
	a_cnt_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		(line_q != '0) && (col_q != '0))
		else $error("line or column counter reached zero");

endmodule
